[sv/mfar_pkg.sv]
// shared types, widths and sequencer states for the mixed fraction adder
package mfar_pkg;

  localparam int MagW   = 31;  // magnitude of the fraction sum and of the gcd
  localparam int DenW   = 30;  // product of two denominators
  localparam int NumW   = 32;  // signed fraction sum
  localparam int WholeW = 17;
  localparam int MulW   = 17;  // signed multiplier operand
  localparam int CntW   = 5;   // divider step counter, 0 .. MagW-1
  localparam int ShW    = 5;   // common power of two found by the gcd

  typedef struct packed {
    logic signed [15:0] whole_a;
    logic signed [15:0] num_a;
    logic        [14:0] den_a;
    logic signed [15:0] whole_b;
    logic signed [15:0] num_b;
    logic        [14:0] den_b;
  } mfar_req_t;

  typedef struct packed {
    logic signed [WholeW-1:0] whole_sum;
    logic signed [NumW-1:0]   num_out;
    logic        [DenW-1:0]   den_out;
  } mfar_rsp_t;

  // control from the sequencer to an iterative unit
  typedef struct packed {
    logic start;
  } mfar_ctl_t;

  // status from an iterative unit back to the sequencer
  typedef struct packed {
    logic done;
  } mfar_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SIGN,
    ST_GCD_GO,
    ST_GCD_WAIT,
    ST_DIVN_GO,
    ST_DIVN_WAIT,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_OUT
  } mfar_state_t;

endpackage

[sv/mfar_gcd.sv]
// binary gcd unit: one shift or subtract step per cycle
module mfar_gcd (
  input  logic                         clk,
  input  logic                         rst,
  input  mfar_pkg::mfar_ctl_t          ctl,
  input  logic [mfar_pkg::MagW-1:0]    x_in,
  input  logic [mfar_pkg::MagW-1:0]    y_in,
  output mfar_pkg::mfar_sts_t          sts,
  output logic [mfar_pkg::MagW-1:0]    g
);

  logic [mfar_pkg::MagW-1:0] x;
  logic [mfar_pkg::MagW-1:0] y;
  logic [mfar_pkg::ShW-1:0]  k;
  logic                      busy;
  logic                      done;
  logic                      fin;
  logic                      x_ge_y;
  logic [mfar_pkg::MagW-1:0] sub;

  assign fin    = (x == '0) || (y == '0);
  assign x_ge_y = x >= y;
  assign sub    = x_ge_y ? (x - y) : (y - x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && fin) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x <= x_in;
      y <= y_in;
      k <= '0;
    end else if (busy && !fin) begin
      if (!x[0] && !y[0]) begin
        // common factor of two, put back at the end
        x <= x >> 1;
        y <= y >> 1;
        k <= k + 1'b1;
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x_ge_y) begin
        x <= sub >> 1;
      end else begin
        y <= sub >> 1;
      end
    end
    if (busy && fin) begin
      g <= (x | y) << k;
    end
  end

  assign sts.done = done;

endmodule

[sv/mfar_div.sv]
// restoring divider, one quotient bit per cycle
module mfar_div (
  input  logic                         clk,
  input  logic                         rst,
  input  mfar_pkg::mfar_ctl_t          ctl,
  input  logic [mfar_pkg::MagW-1:0]    dividend,
  input  logic [mfar_pkg::MagW-1:0]    divisor,
  output mfar_pkg::mfar_sts_t          sts,
  output logic [mfar_pkg::MagW-1:0]    quot
);

  logic [mfar_pkg::MagW-1:0] rem;
  logic [mfar_pkg::MagW-1:0] quo;
  logic [mfar_pkg::CntW-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic [mfar_pkg::MagW:0]   trial;
  logic [mfar_pkg::MagW:0]   diff;
  logic                      fits;

  assign trial = {rem, quo[mfar_pkg::MagW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= mfar_pkg::CntW'(mfar_pkg::MagW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // dividend shifts out of quo while quotient bits shift in
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[mfar_pkg::MagW-1:0] : trial[mfar_pkg::MagW-1:0];
      quo <= {quo[mfar_pkg::MagW-2:0], fits};
    end
  end

  assign quot     = quo;
  assign sts.done = done;

endmodule

[sv/mixed_fraction_add_reduce.sv]
// top level: sequencer, multiplier and result register of the mixed fraction adder
//
// Adds two mixed numbers. The whole parts are summed on their own; the fractions
// are summed as num_a*den_b + den_a*num_b over den_a*den_b and reduced by their gcd.
// A zero numerator gives 0/1, or 0/0 when den_a*den_b is zero; an improper
// fraction is not folded into the whole part. Request channel: req_valid/req_stall
// with payload req. A request is taken when req_valid is high and req_stall low.
// req_stall stays high from the taken request until its result has been taken,
// so one request is in flight at a time. Response channel: rsp_valid/rsp_stall with
// payload rsp, held from registers while rsp_stall is high.
// When the fraction sum and the denominator product are both zero, the gcd is zero
// and the sequencer goes from the gcd wait straight to the output state; otherwise
// the binary gcd runs one shift/subtract step a cycle and the sum and the product
// are then divided by the gcd. The products go through a single 17x17 multiplier
// in MUL1, MUL2 and MUL3, followed by the sign split in SIGN; each of the two passes
// through the shared restoring divider has a start state and a wait state for done.
// A new request is taken only once the sequencer is back in idle after the result
// has been taken, so rsp_stall, while it holds the result, holds off the next one.
// Reset (synchronous, rst high) returns the sequencer to idle and drops rsp_valid.
module mixed_fraction_add_reduce (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mfar_pkg::mfar_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mfar_pkg::mfar_rsp_t rsp
);

  mfar_pkg::mfar_state_t state;
  mfar_pkg::mfar_state_t state_next;

  mfar_pkg::mfar_req_t          req_q;
  logic signed [mfar_pkg::NumW-1:0] prod;
  logic signed [mfar_pkg::NumW-1:0] acc;
  logic [mfar_pkg::NumW-1:0]    acc_abs;
  logic                         neg_q;
  logic [mfar_pkg::MagW-1:0]    mag_q;
  logic [mfar_pkg::DenW-1:0]    den_q;

  logic signed [mfar_pkg::MulW-1:0]   op_x;
  logic signed [mfar_pkg::MulW-1:0]   op_y;
  logic signed [2*mfar_pkg::MulW-1:0] mul_full;

  mfar_pkg::mfar_ctl_t        gcd_ctl;
  mfar_pkg::mfar_sts_t        gcd_sts;
  logic [mfar_pkg::MagW-1:0]  gcd_g;
  mfar_pkg::mfar_ctl_t        div_ctl;
  mfar_pkg::mfar_sts_t        div_sts;
  logic [mfar_pkg::MagW-1:0]  div_dividend;
  logic [mfar_pkg::MagW-1:0]  div_quot;
  logic [mfar_pkg::NumW-1:0]  mag_ext;

  mfar_gcd u_gcd (
    .clk  (clk),
    .rst  (rst),
    .ctl  (gcd_ctl),
    .x_in (mag_q),
    .y_in ({1'b0, den_q}),
    .sts  (gcd_sts),
    .g    (gcd_g)
  );

  mfar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mfar_pkg::ST_IDLE:      if (req_valid) state_next = mfar_pkg::ST_MUL1;
      mfar_pkg::ST_MUL1:      state_next = mfar_pkg::ST_MUL2;
      mfar_pkg::ST_MUL2:      state_next = mfar_pkg::ST_MUL3;
      mfar_pkg::ST_MUL3:      state_next = mfar_pkg::ST_SIGN;
      mfar_pkg::ST_SIGN:      state_next = mfar_pkg::ST_GCD_GO;
      mfar_pkg::ST_GCD_GO:    state_next = mfar_pkg::ST_GCD_WAIT;
      mfar_pkg::ST_GCD_WAIT: begin
        if (gcd_sts.done) begin
          // zero gcd: fraction sum and denominator product are both zero, nothing to reduce
          state_next = (gcd_g == '0) ? mfar_pkg::ST_OUT : mfar_pkg::ST_DIVN_GO;
        end
      end
      mfar_pkg::ST_DIVN_GO:   state_next = mfar_pkg::ST_DIVN_WAIT;
      mfar_pkg::ST_DIVN_WAIT: if (div_sts.done) state_next = mfar_pkg::ST_DIVD_GO;
      mfar_pkg::ST_DIVD_GO:   state_next = mfar_pkg::ST_DIVD_WAIT;
      mfar_pkg::ST_DIVD_WAIT: if (div_sts.done) state_next = mfar_pkg::ST_OUT;
      mfar_pkg::ST_OUT:       if (!rsp_stall) state_next = mfar_pkg::ST_IDLE;
      default:                state_next = mfar_pkg::ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    req_stall     = (state != mfar_pkg::ST_IDLE);
    rsp_valid     = (state == mfar_pkg::ST_OUT);
    gcd_ctl.start = (state == mfar_pkg::ST_GCD_GO);
    div_ctl.start = state inside {mfar_pkg::ST_DIVN_GO, mfar_pkg::ST_DIVD_GO};
    div_dividend  = mag_q;
    op_x          = {2'b00, req_q.den_a};
    op_y          = {2'b00, req_q.den_b};
    case (state)
      mfar_pkg::ST_MUL1: begin
        op_x = {req_q.num_a[15], req_q.num_a};
        op_y = {2'b00, req_q.den_b};
      end
      mfar_pkg::ST_MUL2: begin
        op_x = {req_q.num_b[15], req_q.num_b};
        op_y = {2'b00, req_q.den_a};
      end
      mfar_pkg::ST_DIVD_GO: begin
        div_dividend = {1'b0, den_q};
      end
      default: begin
      end
    endcase
  end

  assign mul_full = op_x * op_y;
  assign acc_abs  = acc[mfar_pkg::NumW-1] ? (~acc + 1'b1) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    case (state)
      mfar_pkg::ST_MUL1: prod <= mul_full[mfar_pkg::NumW-1:0];
      mfar_pkg::ST_MUL2: begin
        prod <= mul_full[mfar_pkg::NumW-1:0];
        acc  <= prod;
      end
      mfar_pkg::ST_MUL3: begin
        prod <= mul_full[mfar_pkg::NumW-1:0];
        acc  <= acc + prod;
      end
      mfar_pkg::ST_SIGN: begin
        neg_q <= acc[mfar_pkg::NumW-1];
        mag_q <= acc_abs[mfar_pkg::MagW-1:0];
        den_q <= prod[mfar_pkg::DenW-1:0];
      end
      mfar_pkg::ST_DIVN_WAIT: if (div_sts.done) mag_q <= div_quot;
      mfar_pkg::ST_DIVD_WAIT: if (div_sts.done) den_q <= div_quot[mfar_pkg::DenW-1:0];
      default: begin
      end
    endcase
  end

  assign mag_ext       = {1'b0, mag_q};
  assign rsp.whole_sum = {req_q.whole_a[15], req_q.whole_a}
                       + {req_q.whole_b[15], req_q.whole_b};
  assign rsp.num_out   = neg_q ? (~mag_ext + 1'b1) : mag_ext;
  assign rsp.den_out   = den_q;

`ifndef SYNTHESIS
  // no new request is taken while a result is still on offer
  a_no_accept_while_rsp: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !rsp_valid) else $error("request taken while result pending");

  // a zero denominator only comes with a zero or unit numerator
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.den_out == '0) |->
      (rsp.num_out == 32'sd0 || rsp.num_out == 32'sd1 || rsp.num_out == -32'sd1))
    else $error("zero denominator with wrong numerator");

  // the two iterative units never finish in the same cycle
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(gcd_sts.done && div_sts.done)) else $error("gcd and divider finished together");

  // a result appears only after a unit has just finished
  a_rsp_after_unit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(gcd_sts.done) || $past(div_sts.done)))
    else $error("result without a finished unit");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for the mixed fraction adder with gcd reduction
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 200;

  class fraction_scoreboard;
    mfar_pkg::mfar_rsp_t pending[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // sum of the two mixed numbers, fraction reduced by its euclidean gcd
    function mfar_pkg::mfar_rsp_t reduced_sum(mfar_pkg::mfar_req_t r);
      longint wa, na, da, wb, nb, db, num, whole;
      longint unsigned den, mag, x, y, g, signed_mag;
      bit neg;
      mfar_pkg::mfar_rsp_t e;
      wa = $signed(r.whole_a);
      na = $signed(r.num_a);
      da = longint'(r.den_a);
      wb = $signed(r.whole_b);
      nb = $signed(r.num_b);
      db = longint'(r.den_b);
      whole = wa + wb;
      num = na * db + da * nb;
      den = da * db;
      neg = num < 0;
      mag = neg ? -num : num;
      x = mag;
      y = den;
      while (x != 0 && y != 0) begin
        if (x > y) x = x % y;
        else y = y % x;
      end
      g = x + y;
      // zero over zero stays unreduced
      if (g != 0) begin
        mag = mag / g;
        den = den / g;
      end
      signed_mag = neg ? -mag : mag;
      e.whole_sum = whole[mfar_pkg::WholeW-1:0];
      e.num_out = signed_mag[mfar_pkg::NumW-1:0];
      e.den_out = den[mfar_pkg::DenW-1:0];
      return e;
    endfunction

    function void note_request(mfar_pkg::mfar_req_t r);
      pending.push_back(reduced_sum(r));
    endfunction

    function void check_result(mfar_pkg::mfar_rsp_t got);
      mfar_pkg::mfar_rsp_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: whole_sum=%0d num_out=%0d den_out=%0d",
                   got.whole_sum, got.num_out, got.den_out);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.whole_sum !== want.whole_sum || got.num_out !== want.num_out ||
          got.den_out !== want.den_out) begin
        if (mismatches < 10) begin
          if (got.whole_sum !== want.whole_sum)
            $display("whole_sum mismatch: expected %0d got %0d",
                     want.whole_sum, got.whole_sum);
          if (got.num_out !== want.num_out)
            $display("num_out mismatch: expected %0d got %0d", want.num_out, got.num_out);
          if (got.den_out !== want.den_out)
            $display("den_out mismatch: expected %0d got %0d", want.den_out, got.den_out);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  mfar_pkg::mfar_req_t req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  mfar_pkg::mfar_rsp_t rsp;

  fraction_scoreboard sums = new();
  int sender_idle_pct = 30;
  int receiver_idle_pct = 51;
  int cycles = 0;

  mixed_fraction_add_reduce dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("mixed_fraction_add_reduce test failed");
      $finish;
    end
  end

  // response side: check taken results, then pick the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sums.check_result(rsp);
    rsp_stall <= rst ? 1'b0 : ($urandom_range(99) < receiver_idle_pct);
  end

  function automatic mfar_pkg::mfar_req_t make_request(int wa, int na, int da,
                                                       int wb, int nb, int db);
    mfar_pkg::mfar_req_t r;
    r.whole_a = wa[15:0];
    r.num_a = na[15:0];
    r.den_a = da[14:0];
    r.whole_b = wb[15:0];
    r.num_b = nb[15:0];
    r.den_b = db[14:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_whole();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_numerator();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h8001;
      3: return 16'h0000;
      4, 5: return 16'($urandom_range(40) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_denominator();
    case ($urandom_range(19))
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'h7fff;
      3, 4, 5, 6, 7: return 15'($urandom_range(64, 1));
      default: return 15'($urandom_range(32767, 1));
    endcase
  endfunction

  function automatic mfar_pkg::mfar_req_t random_request();
    mfar_pkg::mfar_req_t r;
    r.whole_a = pick_whole();
    r.num_a = pick_numerator();
    r.den_a = pick_denominator();
    r.whole_b = pick_whole();
    r.num_b = pick_numerator();
    r.den_b = pick_denominator();
    case ($urandom_range(7))
      // fractions that cancel to zero, unless num_a is -32768
      0: begin
        r.num_b = -r.num_a;
        r.den_b = r.den_a;
      end
      // equal denominators leave a large common factor
      1: r.den_b = r.den_a;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(mfar_pkg::mfar_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sums.note_request(r);
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero denominators, zero numerators, extremes, cancellation, improper sums
    send_request(make_request(0, 0, 0, 0, 0, 0));
    send_request(make_request(1, 3, 0, 2, 0, 5));
    send_request(make_request(-1, -3, 0, 4, 0, 5));
    send_request(make_request(0, -32768, 0, 0, -32768, 0));
    send_request(make_request(0, -32768, 3, 0, 5, 0));
    send_request(make_request(5, 0, 7, -5, 0, 9));
    send_request(make_request(32767, 32767, 32767, 32767, 32767, 32767));
    send_request(make_request(-32768, -32768, 32767, -32768, -32768, 32767));
    send_request(make_request(-32768, -32768, 1, 32767, -32768, 1));
    send_request(make_request(0, 32767, 1, 0, 32767, 1));
    send_request(make_request(0, 1, 32767, 0, 1, 32767));
    send_request(make_request(0, 1, 2, 0, -1, 2));
    send_request(make_request(3, 7, 3, -4, 5, 3));
    send_request(make_request(0, -5, 6, 0, 1, 4));
    send_request(make_request(-32768, 1, 16384, 32767, 1, 16384));
    send_request(make_request(0, -32767, 32767, 0, 32767, 32767));
    send_request(make_request(0, 21845, 10922, 0, -10922, 21845));
    send_request(make_request(0, 12, 18, 0, 6, 9));
    send_request(make_request(0, -1, 1, 0, -1, 1));

    send_random(510);
    sender_idle_pct = 51;
    receiver_idle_pct = 30;
    send_random(515);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    send_random(515);
    req_valid <= 1'b0;

    while (sums.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sums.mismatches == 0 && sums.pending.size() == 0) begin
      $display("mixed_fraction_add_reduce test passed");
    end else begin
      $display("mixed_fraction_add_reduce test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mfar_pkg.sv
sv/mfar_gcd.sv
sv/mfar_div.sv
sv/mixed_fraction_add_reduce.sv
tb/testbench.sv
